[rtl/j3d_pkg.sv]
// ----------------------------------------------------------------------------
// j3d_pkg
// Shared constants, codes and control bundles of the 3D Jacobi stencil core.
// ----------------------------------------------------------------------------
package j3d_pkg;

    localparam int MAX_EDGE_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FIELD_W     = 32;
    localparam int COORD_W     = 5;
    localparam int GSIZE_W     = 6;
    localparam int ITER_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ADDR_W_DEF  = 15;

    // six face neighbours are fetched one per cycle
    localparam int               TAP_W    = 3;
    localparam logic [TAP_W-1:0] TAP_LAST = 3'd5;

    localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 6'd32;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST  = 16'd1000;

    // round(65536 / 6) in Q0.16
    localparam logic signed [15:0] SIXTH_Q16 = 16'sd10923;
    localparam int                 FRAC_BITS = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER  = 2'd1;

    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_CHECK,
        ST_TAP,
        ST_ACC,
        ST_MUL,
        ST_ABS,
        ST_RND,
        ST_CLAMP,
        ST_WRITE,
        ST_SWEEP_END,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load_we;
        logic grid_re;
        logic src_re;
        logic cell_we;
    } mem_ctl_t;

    typedef struct packed {
        logic acc_first;
        logic acc_en;
        logic mul_en;
        logic abs_en;
        logic rnd_en;
        logic clp_en;
    } dp_ctl_t;

    typedef struct packed {
        logic load;
        logic kind;
        logic in_range;
    } resp_t;

endpackage

[rtl/j3d_ram.sv]
// ----------------------------------------------------------------------------
// j3d_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module j3d_ram #(
    parameter int ADDR_W = j3d_pkg::ADDR_W_DEF,
    parameter int DATA_W = j3d_pkg::FIELD_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              re,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/j3d_relax.sv]
// ----------------------------------------------------------------------------
// j3d_relax
// Shared relaxation unit: accumulates the seven terms of one cell, scales by
// one sixth, rounds to nearest (ties away from zero) and saturates.
// ----------------------------------------------------------------------------
module j3d_relax #(
    parameter int VALUE_WIDTH = j3d_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  j3d_pkg::dp_ctl_t    ctl,
    input  logic [((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH)-1:0] grid_data,
    input  logic [((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH)-1:0] src_data,
    output logic [((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH)-1:0] result
);

    import j3d_pkg::*;

    localparam int VW       = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int SW       = VW + 3;
    localparam int PW       = SW + 16;
    localparam int RW       = PW - FRAC_BITS;
    localparam int RND_HALF = 1 << (FRAC_BITS - 1);

    localparam logic [RW-1:0] POS_LIM = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [RW-1:0] NEG_LIM = {{(RW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

    logic signed [VW-1:0] grid_s;
    logic signed [VW-1:0] src_s;
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] acc_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [PW-1:0]        mag_reg;
    logic [PW-1:0]        mag_next;
    logic [PW-1:0]        rnd_sum;
    logic [RW-1:0]        rnd_reg;
    logic [RW-1:0]        neg_rnd;
    logic                 sign_reg;
    logic [VW-1:0]        res_reg;
    logic [VW-1:0]        res_next;

    assign grid_s = grid_data;
    assign src_s  = src_data;

    // one adder: first step loads source plus first neighbour
    assign acc_next  = (ctl.acc_first ? SW'(src_s) : acc_reg) + SW'(grid_s);
    assign prod_next = PW'(acc_reg) * PW'(SIXTH_Q16);
    assign mag_next  = prod_reg[PW-1] ? PW'(-prod_reg) : prod_reg;
    assign rnd_sum   = mag_reg + PW'(RND_HALF);
    assign neg_rnd   = ~rnd_reg + RW'(1);

    always_comb
    begin
        if (sign_reg)
        begin
            res_next = (rnd_reg > NEG_LIM) ? SAT_MIN : neg_rnd[VW-1:0];
        end
        else
        begin
            res_next = (rnd_reg > POS_LIM) ? SAT_MAX : rnd_reg[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.abs_en)
        begin
            mag_reg  <= mag_next;
            sign_reg <= prod_reg[PW-1];
        end
        if (ctl.rnd_en)
        begin
            rnd_reg <= rnd_sum[PW-1:FRAC_BITS];
        end
        if (ctl.clp_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

[rtl/j3d_ctrl.sv]
// ----------------------------------------------------------------------------
// j3d_ctrl
// Sequencer: command decode, sweep and cell walk, neighbour address
// generation and control of the shared relaxation unit.
// ----------------------------------------------------------------------------
module j3d_ctrl #(
    parameter int MAX_EDGE = j3d_pkg::MAX_EDGE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [j3d_pkg::COORD_W-1:0]    cell_x,
    input  logic [j3d_pkg::COORD_W-1:0]    cell_y,
    input  logic [j3d_pkg::COORD_W-1:0]    cell_z,
    input  logic [j3d_pkg::GSIZE_W-1:0]    grid_size,
    input  logic [j3d_pkg::ITER_W-1:0]     max_iterations,
    input  logic                           out_free,
    output j3d_pkg::mem_ctl_t              mem_ctl,
    output logic [3*$clog2(MAX_EDGE)-1:0]  grid_rd_addr,
    output logic [3*$clog2(MAX_EDGE)-1:0]  src_rd_addr,
    output logic [3*$clog2(MAX_EDGE)-1:0]  wr_addr,
    output j3d_pkg::dp_ctl_t               dp_ctl,
    output j3d_pkg::resp_t                 resp,
    output logic                           cur_odd,
    output logic [j3d_pkg::ITER_W-1:0]     sweep_count
);

    import j3d_pkg::*;

    localparam int CW = $clog2(MAX_EDGE);
    localparam int AW = 3 * CW;
    localparam int EW = $clog2(MAX_EDGE + 1);
    localparam int NW = (EW > GSIZE_W) ? EW : GSIZE_W;

    state_t              state_reg;
    state_t              state_next;
    logic [TAP_W-1:0]    tap_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       j_reg;
    logic [CW-1:0]       k_reg;
    logic [NW-1:0]       last_reg;
    logic                small_reg;
    logic [ITER_W-1:0]   sweep_cnt_reg;
    logic                cur_odd_reg;
    logic                kind_reg;
    logic                in_range_reg;

    logic                accept;
    logic                in_range;
    logic [NW-1:0]       gs_ext;
    logic [NW-1:0]       n_eff;
    logic [CW+COORD_W-1:0] x_wide;
    logic [CW+COORD_W-1:0] y_wide;
    logic [CW+COORD_W-1:0] z_wide;
    logic [AW-1:0]       in_addr;
    logic [AW-1:0]       center;
    logic [AW-1:0]       nbr_addr;
    logic [CW-1:0]       im1;
    logic [CW-1:0]       ip1;
    logic [CW-1:0]       jm1;
    logic [CW-1:0]       jp1;
    logic [CW-1:0]       km1;
    logic [CW-1:0]       kp1;
    logic                i_last;
    logic                j_last;
    logic                k_last;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_range = (int'(cell_x) < MAX_EDGE) && (int'(cell_y) < MAX_EDGE)
                   && (int'(cell_z) < MAX_EDGE);

    assign gs_ext = NW'(grid_size);
    assign n_eff  = (gs_ext > NW'(MAX_EDGE)) ? NW'(MAX_EDGE) : gs_ext;

    assign x_wide  = {{CW{1'b0}}, cell_x};
    assign y_wide  = {{CW{1'b0}}, cell_y};
    assign z_wide  = {{CW{1'b0}}, cell_z};
    assign in_addr = {x_wide[CW-1:0], y_wide[CW-1:0], z_wide[CW-1:0]};

    assign im1 = i_reg - CW'(1);
    assign ip1 = i_reg + CW'(1);
    assign jm1 = j_reg - CW'(1);
    assign jp1 = j_reg + CW'(1);
    assign km1 = k_reg - CW'(1);
    assign kp1 = k_reg + CW'(1);

    assign center = {i_reg, j_reg, k_reg};
    assign i_last = (NW'(i_reg) == last_reg);
    assign j_last = (NW'(j_reg) == last_reg);
    assign k_last = (NW'(k_reg) == last_reg);

    always_comb
    begin
        case (tap_reg)
            3'd0:    nbr_addr = {im1, j_reg, k_reg};
            3'd1:    nbr_addr = {ip1, j_reg, k_reg};
            3'd2:    nbr_addr = {i_reg, jm1, k_reg};
            3'd3:    nbr_addr = {i_reg, jp1, k_reg};
            3'd4:    nbr_addr = {i_reg, j_reg, km1};
            default: nbr_addr = {i_reg, j_reg, kp1};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_RUN:  state_next = ST_RUN_CHECK;
                        OP_READ: state_next = ST_RESP;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN_CHECK:
            begin
                if (sweep_cnt_reg == max_iterations)
                begin
                    state_next = ST_RESP;
                end
                else if (small_reg)
                begin
                    state_next = ST_SWEEP_END;
                end
                else
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (tap_reg == TAP_LAST)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_ABS;
            ST_ABS:       state_next = ST_RND;
            ST_RND:       state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (i_last && j_last && k_last)
                begin
                    state_next = ST_SWEEP_END;
                end
                else
                begin
                    state_next = ST_TAP;
                end
            end
            ST_SWEEP_END: state_next = ST_RUN_CHECK;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        mem_ctl      = '0;
        dp_ctl       = '0;
        resp         = '0;
        grid_rd_addr = center;
        src_rd_addr  = center;
        wr_addr      = center;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                grid_rd_addr    = in_addr;
                wr_addr         = in_addr;
                mem_ctl.load_we = in_valid && (opcode == OP_WRITE) && in_range;
                mem_ctl.grid_re = in_valid && (opcode == OP_READ);
            end
            ST_TAP:
            begin
                grid_rd_addr     = nbr_addr;
                mem_ctl.grid_re  = 1'b1;
                mem_ctl.src_re   = (tap_reg == '0);
                dp_ctl.acc_en    = (tap_reg != '0);
                dp_ctl.acc_first = (tap_reg == TAP_W'(1));
            end
            ST_ACC:   dp_ctl.acc_en  = 1'b1;
            ST_MUL:   dp_ctl.mul_en  = 1'b1;
            ST_ABS:   dp_ctl.abs_en  = 1'b1;
            ST_RND:   dp_ctl.rnd_en  = 1'b1;
            ST_CLAMP: dp_ctl.clp_en  = 1'b1;
            ST_WRITE: mem_ctl.cell_we = 1'b1;
            ST_RESP:
            begin
                resp.load     = out_free;
                resp.kind     = kind_reg;
                resp.in_range = in_range_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            last_reg      <= '0;
            small_reg     <= 1'b0;
            sweep_cnt_reg <= '0;
            cur_odd_reg   <= 1'b0;
            kind_reg      <= RES_READ;
            in_range_reg  <= 1'b0;
        end
        else
        begin
            if (accept && (opcode == OP_RUN))
            begin
                last_reg      <= n_eff - NW'(2);
                small_reg     <= (n_eff < NW'(3));
                sweep_cnt_reg <= '0;
                kind_reg      <= RES_DONE;
            end
            if (accept && (opcode == OP_READ))
            begin
                kind_reg     <= RES_READ;
                in_range_reg <= in_range;
            end
            if (state_reg == ST_RUN_CHECK)
            begin
                i_reg   <= CW'(1);
                j_reg   <= CW'(1);
                k_reg   <= CW'(1);
                tap_reg <= '0;
            end
            if (state_reg == ST_TAP)
            begin
                tap_reg <= tap_reg + TAP_W'(1);
            end
            if (state_reg == ST_WRITE)
            begin
                tap_reg <= '0;
                // z fastest, then y, then x
                if (!k_last)
                begin
                    k_reg <= kp1;
                end
                else
                begin
                    k_reg <= CW'(1);
                    if (!j_last)
                    begin
                        j_reg <= jp1;
                    end
                    else
                    begin
                        j_reg <= CW'(1);
                        i_reg <= ip1;
                    end
                end
            end
            if (state_reg == ST_SWEEP_END)
            begin
                cur_odd_reg   <= !cur_odd_reg;
                sweep_cnt_reg <= sweep_cnt_reg + ITER_W'(1);
            end
        end
    end

    assign cur_odd     = cur_odd_reg;
    assign sweep_count = sweep_cnt_reg;

`ifndef SYNTH
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> (tap_reg <= TAP_LAST))
        else $error("neighbour tap out of range");

    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |->
            (i_reg != '0 && NW'(i_reg) <= last_reg && j_reg != '0 &&
             NW'(j_reg) <= last_reg && k_reg != '0 && NW'(k_reg) <= last_reg))
        else $error("sweep touches a boundary cell");

    a_swap_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_odd_reg) |-> ($past(state_reg) == ST_SWEEP_END))
        else $error("grid swap outside sweep end");

    a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        resp.load |=> (state_reg == ST_IDLE))
        else $error("result loaded without returning to idle");
`endif

endmodule

[rtl/jacobi_3d_poisson_stencil_core.sv]
// ----------------------------------------------------------------------------
// jacobi_3d_poisson_stencil_core
// Jacobi relaxation of the 3D Poisson equation on a cubic Q16.16 grid.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready): opcode, cell_x/y/z, start_value,
//     source_value. write loads a cell (start value into both grids), run
//     performs max_iterations sweeps, read returns a cell of the current grid.
//   out channel (out_valid/out_ready): result_kind, cell_value, sweeps_done;
//     one transfer per read or run, none per write.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 grid_size,
//     index 1 max_iterations; always ready, write only while idle.
// Sequence: a write is done in the idle state; a read goes from idle to the
//   result step, which loads the output register once it is free. A run
//   walks the c = (n-2)^3 interior cells (none when n < 3) once per sweep,
//   n = min(grid_size, edge): each interior cell needs six neighbour
//   reads through the single read port of the current grid plus the
//   multiply, round and clamp steps of the shared relaxation unit.
// Reset: grid_size 32, max_iterations 1000, even grid current, output empty;
//   grid memories are not cleared and hold garbage until written.
// Stall: a waiting result holds the next read or run in its result step;
//   writes still proceed while out_ready is low.
// ----------------------------------------------------------------------------
module jacobi_3d_poisson_stencil_core #(
    parameter int MAX_EDGE    = j3d_pkg::MAX_EDGE_DEF,
    parameter int VALUE_WIDTH = j3d_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       opcode,
    input  logic [j3d_pkg::COORD_W-1:0]      cell_x,
    input  logic [j3d_pkg::COORD_W-1:0]      cell_y,
    input  logic [j3d_pkg::COORD_W-1:0]      cell_z,
    input  logic signed [j3d_pkg::FIELD_W-1:0] start_value,
    input  logic signed [j3d_pkg::FIELD_W-1:0] source_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             result_kind,
    output logic signed [j3d_pkg::FIELD_W-1:0] cell_value,
    output logic [j3d_pkg::ITER_W-1:0]       sweeps_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [j3d_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [j3d_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import j3d_pkg::*;

    localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int CW = $clog2(MAX_EDGE);
    localparam int AW = 3 * CW;

    localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

    logic [GSIZE_W-1:0] grid_size_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    logic               out_valid_reg;
    logic               kind_out_reg;
    logic [FIELD_W-1:0] cell_value_reg;
    logic [ITER_W-1:0]  sweeps_reg;
    logic               out_free;

    mem_ctl_t           mem_ctl;
    dp_ctl_t            dp_ctl;
    resp_t              resp;
    logic               cur_odd;
    logic [ITER_W-1:0]  sweep_cnt;
    logic [AW-1:0]      grid_rd_addr;
    logic [AW-1:0]      src_rd_addr;
    logic [AW-1:0]      wr_addr;

    logic               start_fits;
    logic               source_fits;
    logic [VW-1:0]      start_sat;
    logic [VW-1:0]      source_sat;
    logic [VW-1:0]      grid_wr_data;
    logic               even_we;
    logic               odd_we;
    logic [VW-1:0]      even_rd;
    logic [VW-1:0]      odd_rd;
    logic [VW-1:0]      src_rd;
    logic [VW-1:0]      grid_data;
    logic signed [VW-1:0] grid_data_s;
    logic [VW-1:0]      relax_result;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_SIZE: grid_size_reg <= cfg_data[GSIZE_W-1:0];
                CFG_MAX_ITER:  max_iter_reg  <= cfg_data[ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // saturate loaded values to the stored width
    assign start_fits  = (start_value[FIELD_W-1:VW-1]
                          == {(FIELD_W-VW+1){start_value[FIELD_W-1]}});
    assign source_fits = (source_value[FIELD_W-1:VW-1]
                          == {(FIELD_W-VW+1){source_value[FIELD_W-1]}});
    assign start_sat   = start_fits ? start_value[VW-1:0]
                       : (start_value[FIELD_W-1] ? SAT_MIN : SAT_MAX);
    assign source_sat  = source_fits ? source_value[VW-1:0]
                       : (source_value[FIELD_W-1] ? SAT_MIN : SAT_MAX);

    // sweep writes the grid that is not current
    assign grid_wr_data = mem_ctl.load_we ? start_sat : relax_result;
    assign even_we      = mem_ctl.load_we || (mem_ctl.cell_we && cur_odd);
    assign odd_we       = mem_ctl.load_we || (mem_ctl.cell_we && !cur_odd);
    assign grid_data    = cur_odd ? odd_rd : even_rd;
    assign grid_data_s  = grid_data;

    j3d_ctrl #(
        .MAX_EDGE (MAX_EDGE)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .cell_z         (cell_z),
        .grid_size      (grid_size_reg),
        .max_iterations (max_iter_reg),
        .out_free       (out_free),
        .mem_ctl        (mem_ctl),
        .grid_rd_addr   (grid_rd_addr),
        .src_rd_addr    (src_rd_addr),
        .wr_addr        (wr_addr),
        .dp_ctl         (dp_ctl),
        .resp           (resp),
        .cur_odd        (cur_odd),
        .sweep_count    (sweep_cnt)
    );

    j3d_ram #(
        .ADDR_W (AW),
        .DATA_W (VW)
    ) u_grid_even (
        .clk     (clk),
        .we      (even_we),
        .wr_addr (wr_addr),
        .wr_data (grid_wr_data),
        .re      (mem_ctl.grid_re),
        .rd_addr (grid_rd_addr),
        .rd_data (even_rd)
    );

    j3d_ram #(
        .ADDR_W (AW),
        .DATA_W (VW)
    ) u_grid_odd (
        .clk     (clk),
        .we      (odd_we),
        .wr_addr (wr_addr),
        .wr_data (grid_wr_data),
        .re      (mem_ctl.grid_re),
        .rd_addr (grid_rd_addr),
        .rd_data (odd_rd)
    );

    j3d_ram #(
        .ADDR_W (AW),
        .DATA_W (VW)
    ) u_source (
        .clk     (clk),
        .we      (mem_ctl.load_we),
        .wr_addr (wr_addr),
        .wr_data (source_sat),
        .re      (mem_ctl.src_re),
        .rd_addr (src_rd_addr),
        .rd_data (src_rd)
    );

    j3d_relax #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_relax (
        .clk       (clk),
        .ctl       (dp_ctl),
        .grid_data (grid_data),
        .src_data  (src_rd),
        .result    (relax_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp.load)
        begin
            kind_out_reg   <= resp.kind;
            cell_value_reg <= ((resp.kind == RES_READ) && resp.in_range)
                              ? FIELD_W'(grid_data_s) : '0;
            sweeps_reg     <= (resp.kind == RES_DONE) ? sweep_cnt : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_out_reg;
    assign cell_value  = cell_value_reg;
    assign sweeps_done = sweeps_reg;

endmodule

[test/j3d_relax_checker.sv]
// ----------------------------------------------------------------------------
// j3d_relax_checker
// Watches the command, result and register channels of the 3D Jacobi
// stencil core, keeps its own copy of both grids and the source grid, and
// compares every result transfer against the oldest result still due.
// ----------------------------------------------------------------------------
module j3d_relax_checker
    import j3d_pkg::*;
#(
    parameter int MAX_EDGE    = MAX_EDGE_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [COORD_W-1:0]            cell_x,
    input  logic [COORD_W-1:0]            cell_y,
    input  logic [COORD_W-1:0]            cell_z,
    input  logic signed [FIELD_W-1:0]     start_value,
    input  logic signed [FIELD_W-1:0]     source_value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          result_kind,
    input  logic signed [FIELD_W-1:0]     cell_value,
    input  logic [ITER_W-1:0]             sweeps_done,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            fail_count,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CELLS    = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int     EFF_W    = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
    localparam longint SAT_HI   = (longint'(1) <<< (EFF_W - 1)) - 1;
    localparam longint SAT_LO   = -SAT_HI - 1;
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_BITS - 1);

    typedef struct {
        logic                      kind;
        logic signed [FIELD_W-1:0] value;
        logic [ITER_W-1:0]         sweeps;
    } cell_result_t;

    logic signed [FIELD_W-1:0] even_plane   [CELLS];
    logic signed [FIELD_W-1:0] odd_plane    [CELLS];
    logic signed [FIELD_W-1:0] source_plane [CELLS];
    logic                      odd_current;
    logic [GSIZE_W-1:0]        size_cfg;
    logic [ITER_W-1:0]         sweep_cfg;
    cell_result_t              due_results [$];
    int                        mismatches;

    function automatic int cell_at(int x, int y, int z);
        return (x * MAX_EDGE + y) * MAX_EDGE + z;
    endfunction

    function automatic logic signed [FIELD_W-1:0] saturate(longint v);
        if (v > SAT_HI)
            return FIELD_W'(SAT_HI);
        if (v < SAT_LO)
            return FIELD_W'(SAT_LO);
        return FIELD_W'(v);
    endfunction

    function automatic logic signed [FIELD_W-1:0] current_cell(int a);
        return odd_current ? odd_plane[a] : even_plane[a];
    endfunction

    // exact seven-term sum times round(65536/6), rounded half away from zero
    function automatic logic signed [FIELD_W-1:0] sixth_of_sum(longint total);
        longint prod;
        longint rounded;
        prod = total * longint'(SIXTH_Q16);
        if (prod < 0)
            rounded = -((-prod + HALF_LSB) >>> FRAC_BITS);
        else
            rounded = (prod + HALF_LSB) >>> FRAC_BITS;
        return saturate(rounded);
    endfunction

    function automatic void relax_grid(int n);
        longint total;
        int     a;
        for (int i = 1; i + 1 < n; i++) begin
            for (int j = 1; j + 1 < n; j++) begin
                for (int k = 1; k + 1 < n; k++) begin
                    a = cell_at(i, j, k);
                    total = longint'(current_cell(cell_at(i - 1, j, k)))
                          + longint'(current_cell(cell_at(i + 1, j, k)))
                          + longint'(current_cell(cell_at(i, j - 1, k)))
                          + longint'(current_cell(cell_at(i, j + 1, k)))
                          + longint'(current_cell(cell_at(i, j, k - 1)))
                          + longint'(current_cell(cell_at(i, j, k + 1)))
                          + longint'(source_plane[a]);
                    if (odd_current)
                        even_plane[a] = sixth_of_sum(total);
                    else
                        odd_plane[a] = sixth_of_sum(total);
                end
            end
        end
        odd_current = !odd_current;
    endfunction

    function automatic void run_sweeps();
        int n;
        n = (size_cfg > MAX_EDGE) ? MAX_EDGE : int'(size_cfg);
        for (int s = 0; s < int'(sweep_cfg); s++)
            relax_grid(n);
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        cell_result_t want;
        logic         in_range;
        int           a;
        if (!rst_n) begin
            odd_current = 1'b0;
            size_cfg    = GRID_SIZE_RST;
            sweep_cfg   = MAX_ITER_RST;
            due_results.delete();
            outstanding <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing due: result_kind %0d", result_kind);
                    mismatches++;
                end
                else begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        mismatches++;
                    end
                    if (cell_value !== want.value) begin
                        $error("cell_value: expected %0d, got %0d", want.value, cell_value);
                        mismatches++;
                    end
                    if (sweeps_done !== want.sweeps) begin
                        $error("sweeps_done: expected %0d, got %0d", want.sweeps, sweeps_done);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRID_SIZE: size_cfg  = cfg_data[GSIZE_W-1:0];
                    CFG_MAX_ITER:  sweep_cfg = cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                in_range = (cell_x < MAX_EDGE) && (cell_y < MAX_EDGE) && (cell_z < MAX_EDGE);
                a = cell_at(cell_x, cell_y, cell_z);
                case (opcode)
                    OP_WRITE: begin
                        if (in_range) begin
                            even_plane[a]   = saturate(longint'(start_value));
                            odd_plane[a]    = saturate(longint'(start_value));
                            source_plane[a] = saturate(longint'(source_value));
                        end
                    end
                    OP_RUN: begin
                        run_sweeps();
                        due_results.push_back('{RES_DONE, '0, sweep_cfg});
                    end
                    OP_READ: begin
                        due_results.push_back('{RES_READ, in_range ? current_cell(a) : '0, '0});
                    end
                    default: ;
                endcase
            end

            outstanding <= due_results.size();
            fail_count  <= mismatches;
        end
    end

endmodule

[test/tb_jacobi_3d_poisson_stencil_core.sv]
// ----------------------------------------------------------------------------
// tb_jacobi_3d_poisson_stencil_core
// Drives cell loads, reads and sweep runs into the stencil core under many
// grid sizes and sweep counts, with random gaps on the command side and
// random back-pressure on the result side; a checker beside the core
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_jacobi_3d_poisson_stencil_core;
    timeunit 1ns;
    timeprecision 1ps;

    import j3d_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int WATCHDOG_NS = 100_000_000;
    localparam int ITEM_TARGET = 1600;
    localparam int EDGE        = MAX_EDGE_DEF;
    localparam int CELLS       = EDGE * EDGE * EDGE;

    localparam logic [1:0]             OP_NONE     = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE_HI = 2'd3;

    localparam logic signed [FIELD_W-1:0] Q_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] Q_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    opcode;
    logic [COORD_W-1:0]            cell_x;
    logic [COORD_W-1:0]            cell_y;
    logic [COORD_W-1:0]            cell_z;
    logic signed [FIELD_W-1:0]     start_value;
    logic signed [FIELD_W-1:0]     source_value;
    logic                          out_valid;
    logic                          out_ready;
    logic                          result_kind;
    logic signed [FIELD_W-1:0]     cell_value;
    logic [ITER_W-1:0]             sweeps_done;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    int                            fail_count;
    int                            outstanding;

    bit                 cell_loaded [CELLS];
    int                 loaded_cells [$];
    int                 n_loads;
    int                 n_reads;
    int                 n_runs;
    int                 n_settings;
    longint             n_sweeps;
    logic [ITER_W-1:0]  iters_now;
    bit                 no_gaps;

    jacobi_3d_poisson_stencil_core u_dut (.*);

    j3d_relax_checker u_checker (.*);

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int cmd_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    function automatic logic signed [FIELD_W-1:0] sample_q16(bit harsh);
        logic signed [FIELD_W-1:0] v;
        int r;
        r = $urandom_range(0, 99);
        if (harsh && r < 70)
            v = r[0] ? Q_MAX : Q_MIN;
        else if (!harsh && r < 50)
            v = FIELD_W'(int'($urandom_range(0, 524288)) - 262144);
        else if (r < 88)
            v = FIELD_W'($urandom);
        else begin
            case ($urandom_range(0, 4))
                0: v = Q_MAX;
                1: v = Q_MIN;
                2: v = '0;
                3: v = '1;
                default: v = FIELD_W'(1);
            endcase
        end
        return v;
    endfunction

    task automatic send_cmd(logic [1:0] op, int x, int y, int z,
                            logic signed [FIELD_W-1:0] v0, logic signed [FIELD_W-1:0] v1);
        int gap;
        int a;
        gap = cmd_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        cell_x       <= COORD_W'(x);
        cell_y       <= COORD_W'(y);
        cell_z       <= COORD_W'(z);
        start_value  <= v0;
        source_value <= v1;
        do @(posedge clk); while (!in_ready);
        a = (x * EDGE + y) * EDGE + z;
        case (op)
            OP_WRITE: begin
                if (!cell_loaded[a]) begin
                    cell_loaded[a] = 1'b1;
                    loaded_cells.push_back(a);
                end
                n_loads++;
            end
            OP_RUN: begin
                n_runs++;
                n_sweeps += iters_now;
            end
            OP_READ: n_reads++;
            default: ;
        endcase
    endtask

    task automatic load_cell(int x, int y, int z,
                             logic signed [FIELD_W-1:0] v0, logic signed [FIELD_W-1:0] v1);
        send_cmd(OP_WRITE, x, y, z, v0, v1);
    endtask

    task automatic fetch_cell(int x, int y, int z);
        send_cmd(OP_READ, x, y, z, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic start_run();
        send_cmd(OP_RUN, $urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                 $urandom_range(0, EDGE - 1), FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    // drop valid, wait for every due result, then let trailing loads retire
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_ITER)
            iters_now = val;
    endtask

    task automatic set_config(int size_v, int iters_v, bit junk);
        logic [CFG_DATA_W-1:0] d;
        wait_quiet();
        d = CFG_DATA_W'(size_v);
        // bits above the size field are don't-care
        if (junk)
            d[CFG_DATA_W-1:GSIZE_W] = (CFG_DATA_W-GSIZE_W)'($urandom);
        if ($urandom_range(0, 1)) begin
            set_reg(CFG_GRID_SIZE, d);
            set_reg(CFG_MAX_ITER, CFG_DATA_W'(iters_v));
        end
        else begin
            set_reg(CFG_MAX_ITER, CFG_DATA_W'(iters_v));
            set_reg(CFG_GRID_SIZE, d);
        end
        if (junk && $urandom_range(0, 3) == 0)
            set_reg(CFG_INDEX_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)),
                    CFG_DATA_W'($urandom));
        n_settings++;
        no_gaps = ($urandom_range(0, 4) == 0);
    endtask

    // a sweep reads every face of the interior, so load the whole cube first
    task automatic fill_cube(int n, bit harsh);
        for (int x = 0; x < n; x++)
            for (int y = 0; y < n; y++)
                for (int z = 0; z < n; z++)
                    if (!cell_loaded[(x * EDGE + y) * EDGE + z])
                        load_cell(x, y, z, sample_q16(harsh), sample_q16(harsh));
    endtask

    initial begin : result_sink
        int r;
        int stall;
        int open;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            r = $urandom_range(0, 99);
            stall = (r < 50) ? 0 : (r < 80) ? $urandom_range(1, 3) :
                    (r < 95) ? $urandom_range(4, 15) : $urandom_range(16, 80);
            open = (r < 8) ? $urandom_range(100, 300) : $urandom_range(1, 10);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            repeat (open - 1) @(negedge clk);
        end
    end

    initial begin : watchdog
        #WATCHDOG_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int fx [6] = '{0, 2, 1, 1, 1, 1};
        int fy [6] = '{1, 1, 0, 2, 1, 1};
        int fz [6] = '{1, 1, 1, 1, 0, 2};
        int size_v;
        int iters_v;
        int len;
        int r;
        int a;
        bit harsh;
        bit in_cube;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_WRITE;
        cell_x       = '0;
        cell_y       = '0;
        cell_z       = '0;
        start_value  = '0;
        source_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GRID_SIZE;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        iters_now    = MAX_ITER_RST;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest grid: one interior cell fed by six faces
        set_config(3, 1, 1'b0);
        for (int f = 0; f < 6; f++)
            load_cell(fx[f], fy[f], fz[f], Q_MAX, Q_MAX);
        load_cell(1, 1, 1, Q_MAX, Q_MAX);
        start_run();
        fetch_cell(1, 1, 1);

        // three max and three min faces sum to -3, so the source puts the
        // total on exactly +/-0.5 of a quotient step: a rounding tie
        for (int f = 0; f < 6; f += 2)
            load_cell(fx[f], fy[f], fz[f], Q_MIN, Q_MIN);
        load_cell(1, 1, 1, '0, FIELD_W'(32771));
        start_run();
        fetch_cell(1, 1, 1);
        load_cell(1, 1, 1, '0, FIELD_W'(-32765));
        start_run();
        fetch_cell(1, 1, 1);

        send_cmd(OP_NONE, EDGE - 1, EDGE - 1, EDGE - 1, Q_MAX, Q_MIN);
        load_cell(EDGE - 1, EDGE - 1, EDGE - 1, Q_MIN, Q_MAX);
        fetch_cell(EDGE - 1, EDGE - 1, EDGE - 1);

        set_config(3, 0, 1'b0);
        start_run();
        // no interior at all: sweeps only flip the current grid
        set_config(0, (1 << ITER_W) - 1, 1'b0);
        start_run();
        fetch_cell(1, 1, 1);
        set_config((1 << GSIZE_W) - 1, 0, 1'b1);
        start_run();
        set_config(EDGE, 0, 1'b0);
        start_run();

        while (n_loads + n_reads + n_runs < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            harsh = 1'b0;
            if (r < 62) begin
                size_v  = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(3, 5);
                iters_v = $urandom_range(0, 6);
            end
            else if (r < 75) begin
                size_v  = $urandom_range(3, 4);
                iters_v = $urandom_range(1, 4);
                harsh   = 1'b1;
            end
            else if (r < 88) begin
                size_v  = $urandom_range(0, 2);
                iters_v = $urandom_range(0, 2000);
            end
            else begin
                // beyond the loaded cubes: only zero-sweep runs are legal here
                size_v  = $urandom_range(7, (1 << GSIZE_W) - 1);
                iters_v = 0;
            end
            set_config(size_v, iters_v, 1'b1);
            in_cube = (size_v >= 3) && (size_v <= 6);
            if (in_cube)
                fill_cube(size_v, harsh);

            len = $urandom_range(20, 60);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    if (in_cube && $urandom_range(0, 2) != 0)
                        load_cell($urandom_range(0, size_v - 1), $urandom_range(0, size_v - 1),
                                  $urandom_range(0, size_v - 1),
                                  sample_q16(harsh), sample_q16(harsh));
                    else
                        load_cell($urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                                  $urandom_range(0, EDGE - 1),
                                  sample_q16(harsh), sample_q16(harsh));
                end
                else if (r < 78) begin
                    a = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
                    fetch_cell(a / (EDGE * EDGE), (a / EDGE) % EDGE, a % EDGE);
                end
                else if (r < 93)
                    start_run();
                else
                    send_cmd(OP_NONE, $urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                             $urandom_range(0, EDGE - 1), sample_q16(1'b0), sample_q16(1'b0));
            end
        end

        wait_quiet();
        repeat (12) @(posedge clk);
        @(negedge clk);
        $display("covered %0d loads, %0d reads and %0d runs (%0d sweeps) over %0d settings",
                 n_loads, n_reads, n_runs, n_sweeps, n_settings);
        $display("grid edges 0 to 63, sweep counts 0 to 65535, stalls on both channels");
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/j3d_pkg.sv
rtl/j3d_ram.sv
rtl/j3d_relax.sv
rtl/j3d_ctrl.sv
rtl/jacobi_3d_poisson_stencil_core.sv
test/j3d_relax_checker.sv
test/tb_jacobi_3d_poisson_stencil_core.sv
